// ===== hw/rtl/coin_window_classifier_assert.svh =====
// Assertion macros for the coin window classifier.
// No dependencies; taken in by the top level with an include line.
`ifndef COIN_WINDOW_CLASSIFIER_ASSERT_SVH
`define COIN_WINDOW_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define CWC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cwc: property violated");
// expression must never be true out of reset
`define CWC_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("cwc: forbidden condition");
`else
`define CWC_ASSERT(lbl, clk, rst_n, prop)
`define CWC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/cwc_pkg.sv =====
// Shared types, codes and constants of the coin window classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package cwc_pkg;

    // field widths fixed by the stream format
    localparam int RAW_W      = 12;   // raw reading
    localparam int RAW_EXT_W  = 16;   // raw reading, widened for masking
    localparam int BND_W      = 13;   // window bounds, baselines, extremes
    localparam int TYPE_W     = 4;    // type index / coin type
    localparam int SEQ_W      = 16;   // coin sequence count
    localparam int TIU_W      = 5;    // types in use register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int OUTC_W     = 2;

    localparam int NUM_TYPES_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [TIU_W-1:0] TIU_RESET = 5'd11;

    // request kinds carried in the input tuser
    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPES_USED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE2   = 3'd4;

    typedef enum logic [OUTC_W-1:0] {
        OC_MATCH   = 2'd0,
        OC_NONE    = 2'd1,
        OC_OVERLAP = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_scan_state;

    // one table entry: inclusive window per channel
    typedef struct packed {
        logic [BND_W-1:0] high2;
        logic [BND_W-1:0] low2;
        logic [BND_W-1:0] high1;
        logic [BND_W-1:0] low1;
        logic [BND_W-1:0] high0;
        logic [BND_W-1:0] low0;
    } t_window;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // scan engine status toward the top level
    typedef struct packed {
        logic              idle;
        logic              done;
        t_outcome          outcome;
        logic [TYPE_W-1:0] coin_type;
    } t_scan_stat;

    // tracked channel width: channel precision, at least the bound width
    function automatic int track_width(input int sample_bits);
        return (sample_bits + 1 > BND_W) ? sample_bits + 1 : BND_W;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/coin_window_classifier.sv =====
// Top level of the coin window classifier: stream ports, config registers,
// output register. Depends on cwc_pkg, cwc_table, cwc_track, cwc_scan.
`default_nettype none
`include "coin_window_classifier_assert.svh"

// Classifies coins from three sensor readings against a table of windows.
// A write word (tuser 0) loads one table entry, so writes can follow back
// to back; an index at or above NUM_TYPES is dropped. A classify word
// (tuser 1) compares up to min(types_in_use, NUM_TYPES) entries. The table
// sits in a synchronous memory that is read once per cycle, and the window
// compare runs in the cycle after the read. A scan ends after its last
// entry, or early at a second match; the engine then holds its result in
// the done state until the output register is free, and takes the next
// word once it is idle again. With zero types in use the result is
// "no match" and the engine goes straight to the done state. A finished
// result moves into an output register, so one result can wait on a
// stalled downstream while the input takes the next word. A second finished
// result holds the input until that register drains. Entries must be
// written before they are compared; unwritten entries read back undefined
// bounds. Configuration is always ready and must be written only while no
// item is in flight.
module coin_window_classifier #(
    parameter int NUM_TYPES   = cwc_pkg::NUM_TYPES_DEF,
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [cwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [cwc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, low bit up: type_index[3:0], reading0[15:4], reading1[27:16],
    // reading2[39:28], low0[52:40], high0[65:53], low1[78:66],
    // high1[91:79], low2[104:92], high2[117:105], zero pad[119:118]
    input  wire [119:0]                      s_axis_tdata,
    // tuser: req_type[0]
    input  wire                              s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tdata, low bit up: coin_type[3:0], coin_sequence[19:4], min0[32:20],
    // max0[45:33], min1[58:46], max1[71:59], min2[84:72], max2[97:85],
    // zero pad[103:98]
    output logic [103:0]                     m_axis_tdata,
    // tuser: outcome[1:0]
    output logic [cwc_pkg::OUTC_W-1:0]       m_axis_tuser
);
    import cwc_pkg::*;

    localparam int TW   = track_width(SAMPLE_BITS);
    localparam int CHW  = SAMPLE_BITS + 1;
    localparam int IDXW = $clog2(NUM_TYPES);
    localparam int CNTW = $clog2(NUM_TYPES + 1);
    localparam logic [RAW_EXT_W-1:0] SMASK = RAW_EXT_W'((1 << SAMPLE_BITS) - 1);

    // config registers
    logic             r_sample_mode;
    logic [TIU_W-1:0] r_types_in_use;
    t_cfg_wr          cfg;

    // input word fields
    logic [TYPE_W-1:0]      type_index;
    logic [RAW_W-1:0]       reading [3];
    t_window                wr_entry;
    logic                   s_acc;
    logic                   w_start;
    logic                   tbl_wr;

    // channel values
    logic [RAW_EXT_W-1:0]   raw_ext [3];
    logic signed [CHW-1:0]  u [3];
    logic signed [CHW-1:0]  d1, d2;
    logic signed [TW-1:0]   ch [3];
    logic [CNTW-1:0]        count;

    // internal links
    logic                   w_rd_en;
    logic [IDXW-1:0]        w_rd_addr;
    t_window                w_rd_data;
    t_scan_stat             w_stat;
    logic [BND_W-1:0]       w_min [3];
    logic [BND_W-1:0]       w_max [3];
    logic [SEQ_W-1:0]       w_count;
    logic                   load;

    // output register
    logic                   r_m_tvalid;
    t_outcome               r_m_outcome;
    logic [103:0]           r_m_tdata;

    // unpack input word
    assign type_index = s_axis_tdata[3:0];
    assign reading[0] = s_axis_tdata[15:4];
    assign reading[1] = s_axis_tdata[27:16];
    assign reading[2] = s_axis_tdata[39:28];
    assign wr_entry.low0  = s_axis_tdata[52:40];
    assign wr_entry.high0 = s_axis_tdata[65:53];
    assign wr_entry.low1  = s_axis_tdata[78:66];
    assign wr_entry.high1 = s_axis_tdata[91:79];
    assign wr_entry.low2  = s_axis_tdata[104:92];
    assign wr_entry.high2 = s_axis_tdata[117:105];

    // the engine takes a word only when idle
    assign s_axis_tready = w_stat.idle;
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign w_start = s_acc && (s_axis_tuser == REQ_CLASSIFY);
    assign tbl_wr  = s_acc && (s_axis_tuser == REQ_WRITE) && (int'(type_index) < NUM_TYPES);

    // config port
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid && o_cfg_ready;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_mode  <= 1'b0;
            r_types_in_use <= TIU_RESET;
        end else if (cfg.valid) begin
            if (cfg.index == CFG_SAMPLE_MODE) begin
                r_sample_mode <= cfg.data[0];
            end
            if (cfg.index == CFG_TYPES_USED) begin
                r_types_in_use <= cfg.data[TIU_W-1:0];
            end
        end
    end

    // channel values: raw or differential
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            raw_ext[c] = RAW_EXT_W'(reading[c]) & SMASK;
            u[c]       = signed'({1'b0, raw_ext[c][SAMPLE_BITS-1:0]});
        end
        d1 = u[1] - u[0];
        d2 = u[2] - u[1];
        ch[0] = TW'(u[0]);
        ch[1] = r_sample_mode ? TW'(d1) : TW'(u[1]);
        ch[2] = r_sample_mode ? TW'(d2) : TW'(u[2]);
    end

    // entries compared, saturated at the table depth
    assign count = (int'(r_types_in_use) > NUM_TYPES) ? CNTW'(NUM_TYPES)
                                                      : CNTW'(r_types_in_use);

    cwc_table #(
        .NUM_TYPES(NUM_TYPES)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (tbl_wr),
        .i_wr_addr(IDXW'(type_index)),
        .i_wr_data(wr_entry),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    cwc_track #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_track (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg),
        .i_upd  (w_start),
        .i_ch   (ch),
        .o_min  (w_min),
        .o_max  (w_max),
        .o_count(w_count)
    );

    cwc_scan #(
        .NUM_TYPES  (NUM_TYPES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_count  (count),
        .i_ch     (ch),
        .i_take   (load),
        .o_rd_en  (w_rd_en),
        .o_rd_addr(w_rd_addr),
        .i_rd_data(w_rd_data),
        .o_stat   (w_stat)
    );

    // output register: loads when the scan is done and the slot is free
    assign load = w_stat.done && (!r_m_tvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_outcome <= w_stat.outcome;
            r_m_tdata   <= {6'd0, w_max[2], w_min[2], w_max[1], w_min[1],
                            w_max[0], w_min[0], w_count, w_stat.coin_type};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_outcome;

    // checks
    `CWC_ASSERT(a_count_step, i_clk, i_rst_n, w_start |=> w_count == $past(w_count) + 16'd1)
    `CWC_ASSERT(a_type_zero, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser != OC_MATCH)) |-> (m_axis_tdata[3:0] == 4'd0))
    `CWC_NEVER(a_read_idle, i_clk, i_rst_n, w_rd_en && s_axis_tready)
    `CWC_ASSERT(a_valid_src, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(w_stat.done))

endmodule

`default_nettype wire

// ===== hw/rtl/cwc_table.sv =====
// Window table: one write port, one registered read port.
// Depends on cwc_pkg for the entry type.
`default_nettype none

module cwc_table #(
    parameter int NUM_TYPES = cwc_pkg::NUM_TYPES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_wr_en,
    input  wire [$clog2(NUM_TYPES)-1:0]   i_wr_addr,
    input  cwc_pkg::t_window              i_wr_data,
    input  wire                           i_rd_en,
    input  wire [$clog2(NUM_TYPES)-1:0]   i_rd_addr,
    output cwc_pkg::t_window              o_rd_data
);
    import cwc_pkg::*;

    t_window r_mem [NUM_TYPES];
    t_window r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/cwc_track.sv =====
// Running min/max per channel and the coin sequence counter.
// Depends on cwc_pkg for widths, config codes and track_width().
`default_nettype none

module cwc_track #(
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                                i_clk,
    input  wire                                                i_rst_n,
    input  cwc_pkg::t_cfg_wr                                   i_cfg,
    input  wire                                                i_upd,
    input  wire signed [cwc_pkg::track_width(SAMPLE_BITS)-1:0] i_ch [3],
    output logic [cwc_pkg::BND_W-1:0]                          o_min [3],
    output logic [cwc_pkg::BND_W-1:0]                          o_max [3],
    output logic [cwc_pkg::SEQ_W-1:0]                          o_count
);
    import cwc_pkg::*;

    localparam int TW = track_width(SAMPLE_BITS);

    logic signed [TW-1:0] r_min [3];
    logic signed [TW-1:0] r_max [3];
    logic [SEQ_W-1:0]     r_count;

    // baseline writes load both extremes; classify updates them
    for (genvar c = 0; c < 3; c++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_min[c] <= '0;
                r_max[c] <= '0;
            end else if (i_cfg.valid && i_cfg.index == CFG_IDX_W'(CFG_BASELINE0 + c)) begin
                r_min[c] <= TW'(signed'(i_cfg.data));
                r_max[c] <= TW'(signed'(i_cfg.data));
            end else if (i_upd) begin
                if (i_ch[c] < r_min[c]) begin
                    r_min[c] <= i_ch[c];
                end
                if (i_ch[c] > r_max[c]) begin
                    r_max[c] <= i_ch[c];
                end
            end
        end

        assign o_min[c] = r_min[c][BND_W-1:0];
        assign o_max[c] = r_max[c][BND_W-1:0];
    end

    // coin sequence, wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_upd) begin
            r_count <= r_count + SEQ_W'(1);
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/cwc_scan.sv =====
// Scan engine: walks the in-use table entries, one read per cycle,
// and checks each entry's windows in the next cycle. Depends on cwc_pkg.
`default_nettype none

module cwc_scan #(
    parameter int NUM_TYPES   = cwc_pkg::NUM_TYPES_DEF,
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                                i_clk,
    input  wire                                                i_rst_n,
    input  wire                                                i_start,
    input  wire [$clog2(NUM_TYPES+1)-1:0]                      i_count,
    input  wire signed [cwc_pkg::track_width(SAMPLE_BITS)-1:0] i_ch [3],
    input  wire                                                i_take,
    output logic                                               o_rd_en,
    output logic [$clog2(NUM_TYPES)-1:0]                       o_rd_addr,
    input  cwc_pkg::t_window                                   i_rd_data,
    output cwc_pkg::t_scan_stat                                o_stat
);
    import cwc_pkg::*;

    localparam int TW   = track_width(SAMPLE_BITS);
    localparam int IDXW = $clog2(NUM_TYPES);
    localparam int CNTW = $clog2(NUM_TYPES + 1);

    t_scan_state          r_state, n_state;
    logic signed [TW-1:0] r_ch [3];
    logic [CNTW-1:0]      r_n;
    logic [CNTW-1:0]      r_issue;
    logic                 r_cmp_vld;
    logic [IDXW-1:0]      r_cmp_idx;
    logic                 r_found_vld;
    logic [IDXW-1:0]      r_found;
    t_outcome             r_outcome;

    logic signed [TW-1:0] lo [3];
    logic signed [TW-1:0] hi [3];
    logic                 hit;
    logic                 last;
    logic                 finish;
    logic                 start_ok;

    // window compare on the entry read last cycle
    always_comb begin
        lo[0] = TW'(signed'(i_rd_data.low0));
        hi[0] = TW'(signed'(i_rd_data.high0));
        lo[1] = TW'(signed'(i_rd_data.low1));
        hi[1] = TW'(signed'(i_rd_data.high1));
        lo[2] = TW'(signed'(i_rd_data.low2));
        hi[2] = TW'(signed'(i_rd_data.high2));
        hit = r_cmp_vld;
        for (int c = 0; c < 3; c++) begin
            if (r_ch[c] < lo[c] || r_ch[c] > hi[c]) begin
                hit = 1'b0;
            end
        end
    end

    assign last     = (CNTW'(r_cmp_idx) + CNTW'(1)) == r_n;
    assign finish   = (r_state == ST_SCAN) && r_cmp_vld && ((hit && r_found_vld) || last);
    assign start_ok = i_start && (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rd_en          = 1'b0;
        o_stat.idle      = 1'b0;
        o_stat.done      = 1'b0;
        o_stat.outcome   = r_outcome;
        o_stat.coin_type = (r_outcome == OC_MATCH) ? TYPE_W'(r_found) : '0;
        case (r_state)
            ST_IDLE: o_stat.idle = 1'b1;
            ST_SCAN: o_rd_en = (r_issue < r_n);
            ST_DONE: o_stat.done = 1'b1;
            default: o_stat.idle = 1'b0;
        endcase
    end

    assign o_rd_addr = r_issue[IDXW-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= o_rd_en;
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_cmp_idx <= r_issue[IDXW-1:0];
        end
        if (start_ok) begin
            r_ch        <= i_ch;
            r_n         <= i_count;
            r_issue     <= '0;
            r_found_vld <= 1'b0;
            r_outcome   <= OC_NONE;
        end else begin
            if (o_rd_en) begin
                r_issue <= r_issue + CNTW'(1);
            end
            // first hit records the entry, a second one means overlap
            if (r_state == ST_SCAN && hit) begin
                if (r_found_vld) begin
                    r_outcome <= OC_OVERLAP;
                end else begin
                    r_found_vld <= 1'b1;
                    r_found     <= r_cmp_idx;
                    r_outcome   <= OC_MATCH;
                end
            end
        end
    end

endmodule

`default_nettype wire
